// File: src/ogpr_pkg.sv
// Shared constants, types and colour table for the outlined glyph pixel renderer.
// Used by the top level, both checkers and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package ogpr_pkg;

    // glyph geometry
    localparam int GLYPH_W     = 12;
    localparam int GLYPH_H     = 16;
    localparam int GLYPH_COUNT = 26;
    localparam int GLYPH_BYTES = (GLYPH_W * GLYPH_H + 7) / 8;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = $clog2(GLYPH_W * GLYPH_H);
    localparam int LETTER_W    = $clog2(GLYPH_COUNT);

    // request fields
    localparam int LOAD_ADDR_W = 10;
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 8;
    localparam int COL_W       = 4;
    localparam int ROW_W       = 5;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;
    localparam int COLOR_W     = 16;

    // rows of the 3x3 window, one store copy each
    localparam int WIN = 3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_FOLD = 8'd32;

    localparam logic STYLE_NEON  = 1'b0;
    localparam logic STYLE_BLACK = 1'b1;

    typedef enum logic [1:0] {
        LAYER_NONE    = 2'd0,
        LAYER_FACE    = 2'd1,
        LAYER_OUTLINE = 2'd2,
        LAYER_SHADOW  = 2'd3
    } t_layer;

    function automatic logic [COLOR_W-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [COLOR_W-1:0] layer_color(input logic style, input t_layer layer);
        logic [COLOR_W-1:0] c;
        c = '0;
        case ({style, layer})
            {STYLE_NEON,  LAYER_FACE}:    c = pack565(8'd248, 8'd248, 8'd251);
            {STYLE_NEON,  LAYER_OUTLINE}: c = pack565(8'd246, 8'd18,  8'd184);
            {STYLE_NEON,  LAYER_SHADOW}:  c = pack565(8'd100, 8'd30,  8'd143);
            {STYLE_BLACK, LAYER_FACE}:    c = pack565(8'd18,  8'd17,  8'd24);
            {STYLE_BLACK, LAYER_OUTLINE}: c = pack565(8'd94,  8'd49,  8'd113);
            {STYLE_BLACK, LAYER_SHADOW}:  c = pack565(8'd170, 8'd160, 8'd184);
            default:                      c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: src/outlined_glyph_pixel_renderer.sv
// Outlined glyph pixel renderer: glyph store, 3x3 window fetch and layer selection.
// Depends on ogpr_pkg (geometry, field widths, colour table).
// Requests pass stage 1 and the result register; one request per cycle while results
// are taken, set by the three glyph store copies each giving two bytes per cycle.
// Synchronous active-low reset clears the pipeline valids and the style register;
// the glyph store is not cleared and holds nothing meaningful until loaded.
`timescale 1ns / 1ps

module outlined_glyph_pixel_renderer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // style register write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data,   // style
    // requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // load_address[9:0], load_byte[17:10], char_code[25:18], col[29:26], row[34:30]
    input  logic [ogpr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,      // kind
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // drawn[0], layer[2:1], color[18:3]
    output logic [ogpr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = ogpr_pkg::ADDR_W;
    localparam int PW = ogpr_pkg::PIX_W;
    localparam int CW = ogpr_pkg::COL_W;
    localparam int RW = ogpr_pkg::ROW_W;

    // request fields
    logic [ogpr_pkg::LOAD_ADDR_W-1:0] load_address;
    logic [ogpr_pkg::BYTE_W-1:0]      load_byte;
    logic [ogpr_pkg::CHAR_W-1:0]      char_code;
    logic [CW-1:0]                    col;
    logic [RW-1:0]                    row;

    assign load_address = s_tdata[9:0];
    assign load_byte    = s_tdata[17:10];
    assign char_code    = s_tdata[25:18];
    assign col          = s_tdata[29:26];
    assign row          = s_tdata[34:30];

    logic r_style;
    logic r_v1, r_v2;
    logic adv2, accept, wr_en, rd_en;

    assign o_cfg_ready = 1'b1;
    assign adv2        = !r_v2 || m_tready;
    assign s_tready    = !r_v1 || adv2;
    assign accept      = s_tvalid && s_tready;
    assign wr_en       = accept && (s_tuser == ogpr_pkg::KIND_LOAD)
                         && (int'(load_address) < ogpr_pkg::STORE_DEPTH);
    assign rd_en       = accept;

    // ---- stage 0: fold case, locate the three window rows ----
    logic [ogpr_pkg::CHAR_W-1:0]   chr;
    logic                          letter_ok;
    logic [ogpr_pkg::LETTER_W-1:0] letter;
    logic [AW-1:0]                 base;
    logic [CW-1:0]                 xs_raw, xs;
    logic [RW:0]                   ry     [ogpr_pkg::WIN];
    logic                          row_ok [ogpr_pkg::WIN];
    logic [PW-1:0]                 p_lo   [ogpr_pkg::WIN];
    logic [AW-1:0]                 addr0  [ogpr_pkg::WIN];
    logic [AW-1:0]                 addr1  [ogpr_pkg::WIN];

    always_comb begin
        chr = char_code;
        if (char_code >= ogpr_pkg::CHAR_LO_A && char_code <= ogpr_pkg::CHAR_LO_Z) begin
            chr = char_code - ogpr_pkg::CASE_FOLD;
        end
        letter_ok = (chr >= ogpr_pkg::CHAR_UP_A) && (chr <= ogpr_pkg::CHAR_UP_Z);
        letter    = letter_ok ? ogpr_pkg::LETTER_W'(chr - ogpr_pkg::CHAR_UP_A) : '0;
        base      = AW'(int'(letter) * ogpr_pkg::GLYPH_BYTES);
        // leftmost column of the window that can hold a set pixel
        xs_raw    = (col >= CW'(2)) ? col - CW'(2) : '0;
        xs        = (int'(xs_raw) > ogpr_pkg::GLYPH_W - 1) ? CW'(ogpr_pkg::GLYPH_W - 1) : xs_raw;
        for (int dy = 0; dy < ogpr_pkg::WIN; dy++) begin
            ry[dy]     = {1'b0, row} + (RW + 1)'(dy);
            row_ok[dy] = (ry[dy] >= (RW + 1)'(2)) && (int'(ry[dy]) < ogpr_pkg::GLYPH_H + 2);
            p_lo[dy]   = row_ok[dy]
                       ? PW'(int'(ry[dy] - (RW + 1)'(2)) * ogpr_pkg::GLYPH_W) + PW'(xs)
                       : '0;
            addr0[dy]  = base + AW'(p_lo[dy] >> 3);
            addr1[dy]  = (int'(addr0[dy]) == ogpr_pkg::STORE_DEPTH - 1) ? addr0[dy]
                                                                       : addr0[dy] + AW'(1);
        end
    end

    // ---- glyph store: one copy per window row, two byte reads each ----
    logic [7:0] r_rd0 [ogpr_pkg::WIN];
    logic [7:0] r_rd1 [ogpr_pkg::WIN];

    for (genvar gi = 0; gi < ogpr_pkg::WIN; gi++) begin : g_bank
        logic [7:0] r_mem [ogpr_pkg::STORE_DEPTH];
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[AW'(load_address)] <= load_byte;
            end
            if (rd_en) begin
                r_rd0[gi] <= r_mem[addr0[gi]];
                r_rd1[gi] <= r_mem[addr1[gi]];
            end
        end
    end

    // ---- stage 1 registers ----
    logic          r_q1;
    logic [CW-1:0] r_col1, r_xs1;
    logic [2:0]    r_off1 [ogpr_pkg::WIN];
    logic          r_rok1 [ogpr_pkg::WIN];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q1   <= (s_tuser == ogpr_pkg::KIND_QUERY) && letter_ok;
            r_col1 <= col;
            r_xs1  <= xs;
            for (int dy = 0; dy < ogpr_pkg::WIN; dy++) begin
                r_off1[dy] <= p_lo[dy][2:0];
                r_rok1[dy] <= row_ok[dy];
            end
        end
    end

    // ---- stage 1 logic: pick the nine window pixels, resolve layers ----
    logic [2:0][2:0]     nbr;       // [dy][dx], dy/dx = 2 is the queried pixel
    logic [15:0]         word       [ogpr_pkg::WIN];
    logic [CW:0]         cx         [ogpr_pkg::WIN];
    logic                col_ok     [ogpr_pkg::WIN];
    logic [CW:0]         rel        [ogpr_pkg::WIN];
    logic [3:0]          bofs       [ogpr_pkg::WIN][ogpr_pkg::WIN];
    ogpr_pkg::t_layer    layer_s1;
    logic [ogpr_pkg::COLOR_W-1:0] color_s1;

    always_comb begin
        for (int dx = 0; dx < ogpr_pkg::WIN; dx++) begin
            cx[dx]     = {1'b0, r_col1} + (CW + 1)'(dx);
            col_ok[dx] = (cx[dx] >= (CW + 1)'(2)) && (int'(cx[dx]) < ogpr_pkg::GLYPH_W + 2);
            rel[dx]    = cx[dx] - (CW + 1)'(2) - {1'b0, r_xs1};
        end
        for (int dy = 0; dy < ogpr_pkg::WIN; dy++) begin
            word[dy] = {r_rd0[dy], r_rd1[dy]};
            for (int dx = 0; dx < ogpr_pkg::WIN; dx++) begin
                bofs[dy][dx] = 4'(r_off1[dy]) + 4'(rel[dx]);
                nbr[dy][dx]  = r_rok1[dy] && col_ok[dx] && word[dy][4'd15 - bofs[dy][dx]];
            end
        end
        // face wins, then the dilated outline, then the shadow
        if (!r_q1) begin
            layer_s1 = ogpr_pkg::LAYER_NONE;
        end else if (nbr[2][2]) begin
            layer_s1 = ogpr_pkg::LAYER_FACE;
        end else if (|nbr) begin
            layer_s1 = ogpr_pkg::LAYER_OUTLINE;
        end else if (nbr[0][0]) begin
            layer_s1 = ogpr_pkg::LAYER_SHADOW;
        end else begin
            layer_s1 = ogpr_pkg::LAYER_NONE;
        end
        color_s1 = ogpr_pkg::layer_color(r_style, layer_s1);
    end

    // ---- result register ----
    logic [ogpr_pkg::M_TDATA_W-1:0] r_tdata2;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_tdata2 <= {5'b0, color_s1, layer_s1, layer_s1 != ogpr_pkg::LAYER_NONE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_style <= ogpr_pkg::STYLE_NEON;
        end else begin
            if (i_cfg_valid) begin
                r_style <= i_cfg_data;
            end
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv2) begin
                r_v1 <= 1'b0;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign m_tvalid = r_v2;
    assign m_tdata  = r_tdata2;

endmodule

// File: src/ogpr_checker.sv
// Port-level checker for the outlined glyph pixel renderer, bound to the top level.
// Depends on ogpr_pkg for the colour table and layer codes.
`timescale 1ns / 1ps

module ogpr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic                           i_cfg_data,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ogpr_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ogpr_pkg::M_TDATA_W-1:0] m_tdata
);

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // drawn flag agrees with layer, empty pixels carry no colour
    a_drawn_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != ogpr_pkg::LAYER_NONE))
                  && (m_tdata[0] || m_tdata[18:3] == '0)
                  && (m_tdata[23:19] == '0))
        else $error("inconsistent drawn/layer/colour");

    // a painted pixel carries the layer's colour from one of the two schemes
    a_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[0] |->
            (m_tdata[18:3] == ogpr_pkg::layer_color(ogpr_pkg::STYLE_NEON,
                                                    ogpr_pkg::t_layer'(m_tdata[2:1])))
         || (m_tdata[18:3] == ogpr_pkg::layer_color(ogpr_pkg::STYLE_BLACK,
                                                    ogpr_pkg::t_layer'(m_tdata[2:1]))))
        else $error("colour not in palette");

endmodule

bind outlined_glyph_pixel_renderer ogpr_checker u_ogpr_checker (.*);

// File: dv/ogpr_port_checker.sv
// Port checker for the outlined glyph pixel renderer: watches the style, request and
// result channels, keeps its own glyph store and style, predicts each pixel and compares.
// Depends on ogpr_pkg for field widths, character codes and layer names.
`timescale 1ns / 1ps

module ogpr_port_checker
    import ogpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic                 i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int ADDR_LSB = 0;
    localparam int BYTE_LSB = ADDR_LSB + LOAD_ADDR_W;
    localparam int CHAR_LSB = BYTE_LSB + BYTE_W;
    localparam int COL_LSB  = CHAR_LSB + CHAR_W;
    localparam int ROW_LSB  = COL_LSB + COL_W;

    typedef struct packed {
        logic               drawn;
        t_layer             layer;
        logic [COLOR_W-1:0] color;
    } t_pixel;

    logic [BYTE_W-1:0] glyph_bytes [STORE_DEPTH];
    logic              style_now;
    t_pixel            awaited_pixels [$];
    int                fail_count;

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        style_now    = STYLE_NEON;
    end

    // RGB565 of the six scheme colours, worked out by hand from the 8-bit triples
    function automatic logic [COLOR_W-1:0] scheme_colour(input logic st, input t_layer ly);
        logic [COLOR_W-1:0] c;
        c = '0;
        if (st == STYLE_NEON) begin
            case (ly)
                LAYER_FACE:    c = 16'hFFDF;   // 248,248,251
                LAYER_OUTLINE: c = 16'hF097;   // 246,18,184
                LAYER_SHADOW:  c = 16'h60F1;   // 100,30,143
                default:       c = '0;
            endcase
        end else begin
            case (ly)
                LAYER_FACE:    c = 16'h1083;   // 18,17,24
                LAYER_OUTLINE: c = 16'h598E;   // 94,49,113
                LAYER_SHADOW:  c = 16'hAD17;   // 170,160,184
                default:       c = '0;
            endcase
        end
        return c;
    endfunction

    // one bitmap pixel, clear outside the cell
    function automatic logic glyph_pixel(input int base, input int x, input int y);
        int pix;
        if (x < 0 || x >= GLYPH_W || y < 0 || y >= GLYPH_H) return 1'b0;
        pix = y * GLYPH_W + x;
        return glyph_bytes[base + pix / 8][7 - (pix % 8)];
    endfunction

    // any pixel set in the 3x3 neighbourhood
    function automatic logic glyph_near(input int base, input int x, input int y);
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                if (glyph_pixel(base, x + dx, y + dy)) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_pixel render_pixel(input logic [CHAR_W-1:0] ch,
                                            input logic [COL_W-1:0] col,
                                            input logic [ROW_W-1:0] row);
        t_pixel            px;
        logic [CHAR_W-1:0] up;
        int                base;
        int                x;
        int                y;
        px = '{1'b0, LAYER_NONE, '0};
        up = ch;
        if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) up = ch - CASE_FOLD;
        if (up < CHAR_UP_A || up > CHAR_UP_Z) return px;
        base = int'(up - CHAR_UP_A) * GLYPH_BYTES;
        x    = int'(col);
        y    = int'(row);
        if (glyph_pixel(base, x, y))               px.layer = LAYER_FACE;
        else if (glyph_near(base, x - 1, y - 1))   px.layer = LAYER_OUTLINE;
        else if (glyph_pixel(base, x - 2, y - 2))  px.layer = LAYER_SHADOW;
        if (px.layer != LAYER_NONE) begin
            px.drawn = 1'b1;
            px.color = scheme_colour(style_now, px.layer);
        end
        return px;
    endfunction

    task automatic compare_field(input string what, input logic [COLOR_W-1:0] want,
                                 input logic [COLOR_W-1:0] seen);
        if (seen !== want) begin
            $display("%0t ns  %s: expected %0h, got %0h", $time, what, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel            want;
        logic [9:0]        addr;
        if (!i_rst_n) begin
            style_now = STYLE_NEON;
        end else begin
            if (i_cfg_valid && i_cfg_ready) style_now = i_cfg_data;

            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == KIND_LOAD) begin
                    addr = i_s_tdata[ADDR_LSB +: LOAD_ADDR_W];
                    if (addr < STORE_DEPTH) glyph_bytes[addr] = i_s_tdata[BYTE_LSB +: BYTE_W];
                    awaited_pixels.push_back('{1'b0, LAYER_NONE, '0});
                end else begin
                    awaited_pixels.push_back(render_pixel(i_s_tdata[CHAR_LSB +: CHAR_W],
                                                          i_s_tdata[COL_LSB +: COL_W],
                                                          i_s_tdata[ROW_LSB +: ROW_W]));
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                if (awaited_pixels.size() == 0) begin
                    $display("%0t ns  result: expected none, got %0h", $time, i_m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_pixels.pop_front();
                    compare_field("drawn", COLOR_W'(want.drawn), COLOR_W'(i_m_tdata[0]));
                    compare_field("layer", COLOR_W'(want.layer), COLOR_W'(i_m_tdata[2:1]));
                    compare_field("color", want.color, i_m_tdata[18:3]);
                end
            end
        end
        o_pending    <= awaited_pixels.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: dv/testbench.sv
// Top of the renderer testbench: clock, reset, style writes, glyph loads and pixel queries
// with random gaps on both sides. Depends on ogpr_pkg, ogpr_port_checker and the block.
`timescale 1ns / 1ps

module testbench;
    import ogpr_pkg::*;

    localparam int TOTAL_ITEMS  = 2000;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 i_cfg_data;
    logic                 s_tvalid;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tready;
    wire                  o_cfg_ready;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int send_gap_max  = 0;
    int take_gap_max  = 0;
    bit hold_off_req  = 1'b0;
    bit letter_ready [GLYPH_COUNT];

    outlined_glyph_pixel_renderer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    ogpr_port_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // tdata: load_address, load_byte, char_code, col, row from bit 0 up
    function automatic logic [S_TDATA_W-1:0] request_word(input logic [9:0] addr,
                                                          input logic [7:0] bt,
                                                          input logic [7:0] ch,
                                                          input logic [3:0] col,
                                                          input logic [4:0] row);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[ROW_W+COL_W+CHAR_W+BYTE_W+LOAD_ADDR_W-1:0] = {row, col, ch, bt, addr};
        return w;
    endfunction

    task automatic send_request(input logic kind, input logic [S_TDATA_W-1:0] word);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // fields the load does not use carry random values
    task automatic send_load(input logic [9:0] addr, input logic [7:0] bt);
        send_request(KIND_LOAD, request_word(addr, bt, 8'($urandom_range(255, 0)),
                                             4'($urandom_range(13, 0)),
                                             5'($urandom_range(17, 0))));
    endtask

    task automatic send_query(input logic [7:0] ch, input logic [3:0] col, input logic [4:0] row);
        send_request(KIND_QUERY, request_word(10'($urandom_range(1023, 0)),
                                              8'($urandom_range(255, 0)), ch, col, row));
    endtask

    task automatic load_glyph(input int letter);
        int          mode;
        int          lit;
        logic [7:0]  bt;
        mode = $urandom_range(4, 0);
        lit  = $urandom_range(GLYPH_BYTES - 1, 0);
        for (int b = 0; b < GLYPH_BYTES; b++) begin
            case (mode)
                0:       bt = 8'($urandom);
                1:       bt = 8'($urandom & $urandom & $urandom);   // sparse
                2:       bt = 8'($urandom | $urandom);               // dense
                3:       bt = (b == lit) ? 8'(1 << $urandom_range(7, 0)) : 8'h00;
                default: bt = 8'hFF;
            endcase
            send_load(10'(letter * GLYPH_BYTES + b), bt);
        end
        letter_ready[letter] = 1'b1;
    endtask

    // only letters whose whole bitmap has been loaded are ever drawn
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        int         idx;
        if ($urandom_range(99, 0) < 80) begin
            do idx = $urandom_range(GLYPH_COUNT - 1, 0); while (!letter_ready[idx]);
            c = CHAR_UP_A + 8'(idx);
            if ($urandom_range(1, 0) == 1) c = c + CASE_FOLD;
        end else begin
            do begin
                c   = 8'($urandom_range(255, 0));
                idx = -1;
                if (c >= CHAR_UP_A && c <= CHAR_UP_Z) idx = int'(c - CHAR_UP_A);
                if (c >= CHAR_LO_A && c <= CHAR_LO_Z) idx = int'(c - CHAR_LO_A);
            end while (idx >= 0 && !letter_ready[idx]);
        end
        return c;
    endfunction

    // stop offering, let every pending result arrive, then idle before returning
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_style(input logic st);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= st;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result side, with its own gaps and the long hold-off
    initial begin : result_sink
        int gap;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            gap = $urandom_range(take_gap_max, 0);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int         ph;
        int         n;
        logic [7:0] bt;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= KIND_LOAD;
        s_tdata     <= '0;
        for (int l = 0; l < GLYPH_COUNT; l++) letter_ready[l] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // letter A: top-left corner, bottom-right corner and one pixel at (6,8)
        for (int b = 0; b < GLYPH_BYTES; b++) begin
            bt = 8'h00;
            if (b == 0)               bt = 8'h80;
            if (b == 12)              bt = 8'h02;
            if (b == GLYPH_BYTES - 1) bt = 8'h01;
            send_load(10'(b), bt);
        end
        letter_ready[0] = 1'b1;

        // writes past the end of the store are dropped
        send_load(10'(STORE_DEPTH), 8'hFF);
        send_load(10'h3FF, 8'hFF);

        send_query(CHAR_UP_A, 4'd0, 5'd0);
        send_query(CHAR_LO_A, 4'd0, 5'd0);
        send_query(CHAR_UP_A, 4'd1, 5'd1);
        send_query(CHAR_UP_A, 4'd2, 5'd2);      // shadow hidden under outline
        send_query(CHAR_UP_A, 4'd11, 5'd15);
        send_query(CHAR_UP_A, 4'd12, 5'd16);
        send_query(CHAR_UP_A, 4'd13, 5'd17);
        send_query(CHAR_UP_A, 4'd6, 5'd8);
        send_query(CHAR_UP_A, 4'd8, 5'd10);
        send_query(CHAR_UP_A, 4'd5, 5'd3);
        send_query(CHAR_UP_A, 4'd13, 5'd0);
        send_query(CHAR_LO_A, 4'd0, 5'd17);
        send_query(8'h00, 4'd0, 5'd0);
        send_query(8'hFF, 4'd13, 5'd17);
        send_query(CHAR_UP_A - 8'd1, 4'd0, 5'd0);
        send_query(CHAR_UP_Z + 8'd1, 4'd0, 5'd0);
        send_query(CHAR_LO_A - 8'd1, 4'd0, 5'd0);
        send_query(CHAR_LO_Z + 8'd1, 4'd0, 5'd0);

        ph = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (ph == 0)      write_style(STYLE_BLACK);
            else if (ph == 1) write_style(STYLE_NEON);
            else              write_style(1'($urandom_range(1, 0)));

            case ((ph < 4) ? ph : $urandom_range(3, 0))
                2: begin
                    // receiver stalls for a long while, sender keeps pushing
                    send_gap_max = 0;
                    take_gap_max = 12;
                    hold_off_req = 1'b1;
                end
                3: begin
                    send_gap_max = 0;
                    take_gap_max = 0;
                end
                default: begin
                    send_gap_max = 12;
                    take_gap_max = 12;
                end
            endcase

            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(99, 0) < 20) begin
                    load_glyph($urandom_range(GLYPH_COUNT - 1, 0));
                    n += GLYPH_BYTES;
                end else begin
                    repeat ($urandom_range(40, 8)) begin
                        if ($urandom_range(99, 0) < 88)
                            send_query(pick_char(), 4'($urandom_range(13, 0)),
                                       5'($urandom_range(17, 0)));
                        else
                            send_load(10'($urandom_range(1023, 0)), 8'($urandom_range(255, 0)));
                        n++;
                    end
                end
            end
            ph++;
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: outlined_glyph_pixel_renderer.f
src/ogpr_pkg.sv
src/outlined_glyph_pixel_renderer.sv
src/ogpr_checker.sv
dv/ogpr_port_checker.sv
dv/testbench.sv
